FILE: rtl/rotation_matrix_to_quaternion_top_macros.svh
// Assertion macros shared by the rotation-matrix-to-quaternion RTL.
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_MACROS_SVH

// checked only outside reset
`define RMQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define RMQ_ASSERT_NR(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/rmq_pkg.sv
// Types, widths and helpers for the rotation-matrix-to-quaternion block.
package rmq_pkg;

   localparam int FRAC_BITS = 14;
   localparam int EL_W  = 16;                 // matrix element / quaternion width
   localparam int A_W   = 18;                 // trace and root argument, signed
   localparam int MAG_W = 17;                 // |difference| of two elements
   localparam int SQ_W  = 15;                 // root bits = number of root cells
   localparam int SR_W  = SQ_W + 2;           // root remainder
   localparam int RAD_W = 2 * SQ_W;           // radicand
   localparam int NUM_W = MAG_W + FRAC_BITS;  // dividend
   localparam int DEN_W = SQ_W + 2;           // divisor 4*P
   localparam int QUO_W = 23;                 // quotient bits = number of divider cells
   localparam int PRE_W = NUM_W - QUO_W;      // leading dividend bits, always below the divisor
   localparam int NS    = 1 + SQ_W + 1 + QUO_W + 1;

   // component indexes x y z w; the response stores the components as w x y z
   localparam logic [1:0] IDX_X = 2'd0;
   localparam logic [1:0] IDX_Y = 2'd1;
   localparam logic [1:0] IDX_Z = 2'd2;
   localparam logic [1:0] IDX_W = 2'd3;

   typedef struct packed {
      logic signed [EL_W-1:0] m00;
      logic signed [EL_W-1:0] m01;
      logic signed [EL_W-1:0] m02;
      logic signed [EL_W-1:0] m10;
      logic signed [EL_W-1:0] m11;
      logic signed [EL_W-1:0] m12;
      logic signed [EL_W-1:0] m20;
      logic signed [EL_W-1:0] m21;
      logic signed [EL_W-1:0] m22;
   } req_data_type;

   typedef struct packed {
      logic signed [EL_W-1:0] qw;
      logic signed [EL_W-1:0] qx;
      logic signed [EL_W-1:0] qy;
      logic signed [EL_W-1:0] qz;
      logic                   degenerate;
   } rsp_data_type;

   // per-transaction routing that rides along the pipeline
   typedef struct packed {
      logic            degen;
      logic [1:0]      big;
      logic [2:0][1:0] dest;
      logic [2:0]      neg;
   } side_type;

   function automatic logic signed [EL_W-1:0] sat_comp(input logic [QUO_W-1:0] mag,
                                                        input logic neg);
      logic signed [EL_W-1:0] res;
      if (!neg) begin
         if (mag > QUO_W'(32767)) res = 16'sh7fff;
         else                     res = mag[EL_W-1:0];
      end else begin
         if (mag > QUO_W'(32768)) res = 16'sh8000;
         else                     res = -mag[EL_W-1:0];
      end
      return res;
   endfunction

endpackage

FILE: rtl/rmq_chan_if.sv
// Valid/ready channel interfaces for request and response transactions.
interface rmq_req_if;
   import rmq_pkg::*;
   logic         valid;
   logic         ready;
   req_data_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface rmq_rsp_if;
   import rmq_pkg::*;
   logic         valid;
   logic         ready;
   rsp_data_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/rmq_sqrt_cell.sv
// One digit of the restoring square root: two radicand bits in, one root bit out.
module rmq_sqrt_cell (
   input  logic                       clock,
   input  logic                       en,
   input  logic [rmq_pkg::SR_W-1:0]   rem_in,
   input  logic [rmq_pkg::SQ_W-1:0]   root_in,
   input  logic [rmq_pkg::RAD_W-1:0]  rad_in,
   output logic [rmq_pkg::SR_W-1:0]   rem_ff,
   output logic [rmq_pkg::SQ_W-1:0]   root_ff,
   output logic [rmq_pkg::RAD_W-1:0]  rad_ff
);
   import rmq_pkg::*;

   logic [SR_W-1:0]  shifted;
   logic [SR_W-1:0]  trial;
   logic             ge;
   logic [SR_W-1:0]  rem_in_nx;
   logic [SQ_W-1:0]  root_in_nx;
   logic [RAD_W-1:0] rad_in_nx;

   always_comb begin
      shifted    = {rem_in[SR_W-3:0], rad_in[RAD_W-1 -: 2]};
      trial      = {root_in, 2'b01};
      ge         = shifted >= trial;
      rem_in_nx  = ge ? shifted - trial : shifted;
      root_in_nx = {root_in[SQ_W-2:0], ge};
      rad_in_nx  = {rad_in[RAD_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in_nx;
         root_ff <= root_in_nx;
         rad_ff  <= rad_in_nx;
      end
   end

endmodule

FILE: rtl/rmq_div_cell.sv
// One step of the restoring divider: one dividend bit in, one quotient bit out.
module rmq_div_cell (
   input  logic                       clock,
   input  logic                       en,
   input  logic [rmq_pkg::DEN_W-1:0]  rem_in,
   input  logic [rmq_pkg::QUO_W-1:0]  num_in,
   input  logic [rmq_pkg::DEN_W-1:0]  den_in,
   input  logic [rmq_pkg::QUO_W-1:0]  quo_in,
   output logic [rmq_pkg::DEN_W-1:0]  rem_ff,
   output logic [rmq_pkg::QUO_W-1:0]  num_ff,
   output logic [rmq_pkg::DEN_W-1:0]  den_ff,
   output logic [rmq_pkg::QUO_W-1:0]  quo_ff
);
   import rmq_pkg::*;

   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;
   logic [DEN_W-1:0] rem_in_nx;

   always_comb begin
      trial     = {rem_in, num_in[QUO_W-1]};
      diff      = trial - {1'b0, den_in};
      ge        = trial >= {1'b0, den_in};
      rem_in_nx = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in_nx;
         num_ff <= {num_in[QUO_W-2:0], 1'b0};
         den_ff <= den_in;
         quo_ff <= {quo_in[QUO_W-2:0], ge};
      end
   end

endmodule

FILE: rtl/rotation_matrix_to_quaternion_top.sv
// Throughput: one transaction per cycle while the skid register is empty; the pipeline is
// a prep register, 15 square-root cells, a rounding register and 23 divider cells, then an
// output register, all advancing together, and a skid register behind them.
// A waiting response sits in the skid register and holds the pipeline and req_chan.ready.
// Reset (synchronous, active high) clears all stage valid bits and the skid valid flag.
`include "rotation_matrix_to_quaternion_top_macros.svh"
module rotation_matrix_to_quaternion_top (
   input logic        clock,
   input logic        reset,
   rmq_req_if.sink    req_chan,
   rmq_rsp_if.source  rsp_chan
);
   import rmq_pkg::*;

   localparam int S_RND = 1 + SQ_W;   // rounding stage
   localparam int S_OUT = NS - 1;     // output stage

   // ---------------------------------------------------------------- control
   logic [NS-1:0] vld_ff, vld_in;
   logic          skid_vld_ff, skid_vld_in;
   logic          adv;               // whole pipeline moves one step

   assign adv            = !skid_vld_ff;
   assign req_chan.ready = adv;

   always_comb begin
      vld_in = adv ? {vld_ff[NS-2:0], req_chan.valid} : vld_ff;
      if (skid_vld_ff) skid_vld_in = !rsp_chan.ready;
      else             skid_vld_in = vld_ff[S_OUT] && !rsp_chan.ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         skid_vld_ff <= 1'b0;
      end else begin
         vld_ff      <= vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   // ---------------------------------------------------------------- prep stage
   // Shepperd branch choice, root argument and the three off-diagonal terms.
   logic signed [EL_W-1:0] mm [3][3];
   logic signed [A_W-1:0]  trace, a_arg, one;
   logic                   tpos;
   logic [1:0]             ii, jj, kk;
   logic signed [A_W-1:0]  dd [3];
   side_type               side_pre;
   logic [2:0][MAG_W-1:0]  mag_pre;
   logic [RAD_W-1:0]       rad_pre;

   always_comb begin
      mm[0][0] = req_chan.data.m00; mm[0][1] = req_chan.data.m01; mm[0][2] = req_chan.data.m02;
      mm[1][0] = req_chan.data.m10; mm[1][1] = req_chan.data.m11; mm[1][2] = req_chan.data.m12;
      mm[2][0] = req_chan.data.m20; mm[2][1] = req_chan.data.m21; mm[2][2] = req_chan.data.m22;
      one   = A_W'(1) <<< FRAC_BITS;
      trace = A_W'(mm[0][0]) + A_W'(mm[1][1]) + A_W'(mm[2][2]);
      tpos  = trace > 0;
      // largest diagonal element, ties keep the lower index
      ii = IDX_X;
      if (mm[1][1] > mm[0][0]) ii = IDX_Y;
      if (mm[2][2] > mm[ii][ii]) ii = IDX_Z;
      unique case (ii)
         IDX_X:   begin jj = IDX_Y; kk = IDX_Z; end
         IDX_Y:   begin jj = IDX_Z; kk = IDX_X; end
         default: begin jj = IDX_X; kk = IDX_Y; end
      endcase
      side_pre = '0;
      if (tpos) begin
         a_arg            = trace + one;
         dd[0]            = A_W'(mm[2][1]) - A_W'(mm[1][2]);
         dd[1]            = A_W'(mm[0][2]) - A_W'(mm[2][0]);
         dd[2]            = A_W'(mm[1][0]) - A_W'(mm[0][1]);
         side_pre.big     = IDX_W;
         side_pre.dest[0] = IDX_X;
         side_pre.dest[1] = IDX_Y;
         side_pre.dest[2] = IDX_Z;
      end else begin
         a_arg            = A_W'(mm[ii][ii]) - (A_W'(mm[jj][jj]) + A_W'(mm[kk][kk])) + one;
         dd[0]            = A_W'(mm[kk][jj]) - A_W'(mm[jj][kk]);
         dd[1]            = A_W'(mm[jj][ii]) + A_W'(mm[ii][jj]);
         dd[2]            = A_W'(mm[kk][ii]) + A_W'(mm[ii][kk]);
         side_pre.big     = ii;
         side_pre.dest[0] = IDX_W;
         side_pre.dest[1] = jj;
         side_pre.dest[2] = kk;
      end
      side_pre.degen = !tpos && (a_arg <= 0);
      for (int l = 0; l < 3; l++) begin
         side_pre.neg[l] = dd[l][A_W-1];
         mag_pre[l]      = dd[l][A_W-1] ? MAG_W'(-dd[l]) : MAG_W'(dd[l]);
      end
      // radicand = A * 2^(F-2); zero for a degenerate matrix
      if (side_pre.degen) rad_pre = '0;
      else                rad_pre = {1'b0, a_arg[MAG_W-1:0], {(FRAC_BITS-2){1'b0}}};
   end

   // side data and magnitudes ride along as shift lines
   side_type              side_ff [NS-1];
   logic [2:0][MAG_W-1:0] mag_ff  [SQ_W+1];
   logic [RAD_W-1:0]      rad0_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_pre;
         mag_ff[0]  <= mag_pre;
         rad0_ff    <= rad_pre;
         for (int s = 1; s < NS-1; s++) side_ff[s] <= side_ff[s-1];
         for (int s = 1; s <= SQ_W; s++) mag_ff[s] <= mag_ff[s-1];
      end
   end

   // ---------------------------------------------------------------- square root chain
   logic [SR_W-1:0]  sq_rem  [SQ_W+1];
   logic [SQ_W-1:0]  sq_root [SQ_W+1];
   logic [RAD_W-1:0] sq_rad  [SQ_W+1];

   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_rad[0]  = rad0_ff;

   for (genvar c = 0; c < SQ_W; c++) begin : g_sq
      rmq_sqrt_cell u_cell (
         .clock   (clock),
         .en      (adv),
         .rem_in  (sq_rem[c]),
         .root_in (sq_root[c]),
         .rad_in  (sq_rad[c]),
         .rem_ff  (sq_rem[c+1]),
         .root_ff (sq_root[c+1]),
         .rad_ff  (sq_rad[c+1])
      );
   end

   // ---------------------------------------------------------------- rounding stage
   // P = root rounded to nearest; dividend = |D| * 2^F + 2P, divisor 4P
   logic [SQ_W-1:0]  p_rnd;
   logic [NUM_W-1:0] num_rnd [3];
   logic [SQ_W-1:0]  p_ff    [QUO_W+1];
   logic [DEN_W-1:0] dv_rem  [3][QUO_W+1];
   logic [QUO_W-1:0] dv_num  [3][QUO_W+1];
   logic [DEN_W-1:0] dv_den  [3][QUO_W+1];
   logic [QUO_W-1:0] dv_quo  [3][QUO_W+1];
   logic [DEN_W-1:0] rem0_ff [3];
   logic [QUO_W-1:0] num0_ff [3];
   logic [DEN_W-1:0] den0_ff;

   always_comb begin
      p_rnd = sq_root[SQ_W] + SQ_W'(sq_rem[SQ_W] > {2'b00, sq_root[SQ_W]});
      for (int l = 0; l < 3; l++) begin
         num_rnd[l] = {mag_ff[SQ_W][l], {FRAC_BITS{1'b0}}} + NUM_W'({p_rnd, 1'b0});
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff[0] <= p_rnd;
         den0_ff <= {p_rnd, 2'b00};
         for (int l = 0; l < 3; l++) begin
            rem0_ff[l] <= DEN_W'(num_rnd[l][NUM_W-1 -: PRE_W]);
            num0_ff[l] <= num_rnd[l][QUO_W-1:0];
         end
         for (int s = 1; s <= QUO_W; s++) p_ff[s] <= p_ff[s-1];
      end
   end

   // ---------------------------------------------------------------- divider chains
   for (genvar l = 0; l < 3; l++) begin : g_lane
      assign dv_rem[l][0] = rem0_ff[l];
      assign dv_num[l][0] = num0_ff[l];
      assign dv_den[l][0] = den0_ff;
      assign dv_quo[l][0] = '0;
      for (genvar c = 0; c < QUO_W; c++) begin : g_dv
         rmq_div_cell u_cell (
            .clock  (clock),
            .en     (adv),
            .rem_in (dv_rem[l][c]),
            .num_in (dv_num[l][c]),
            .den_in (dv_den[l][c]),
            .quo_in (dv_quo[l][c]),
            .rem_ff (dv_rem[l][c+1]),
            .num_ff (dv_num[l][c+1]),
            .den_ff (dv_den[l][c+1]),
            .quo_ff (dv_quo[l][c+1])
         );
      end
   end

   // ---------------------------------------------------------------- output stage
   // sign, saturation and placement of each component
   side_type               side_last;
   logic signed [EL_W-1:0] qv [4];
   rsp_data_type           out_in, out_ff, skid_ff;

   always_comb begin
      side_last = side_ff[NS-2];
      for (int n = 0; n < 4; n++) qv[n] = '0;
      if (!side_last.degen) begin
         qv[side_last.big] = sat_comp(QUO_W'(p_ff[QUO_W]), 1'b0);
         for (int l = 0; l < 3; l++) begin
            qv[side_last.dest[l]] = sat_comp(dv_quo[l][QUO_W], side_last.neg[l]);
         end
      end
      out_in.qw         = qv[IDX_W];
      out_in.qx         = qv[IDX_X];
      out_in.qy         = qv[IDX_Y];
      out_in.qz         = qv[IDX_Z];
      out_in.degenerate = side_last.degen;
   end

   always_ff @(posedge clock) begin
      if (adv) out_ff <= out_in;
      if (!skid_vld_ff) skid_ff <= out_ff;
   end

   assign rsp_chan.valid = skid_vld_ff || vld_ff[S_OUT];
   assign rsp_chan.data  = skid_vld_ff ? skid_ff : out_ff;

   // ---------------------------------------------------------------- assertions
   `RMQ_ASSERT(a_accept_fills, (req_chan.valid && req_chan.ready) |=> vld_ff[0], "accepted transaction did not enter the pipeline")
   `RMQ_ASSERT(a_degen_zero, (rsp_chan.valid && rsp_chan.data.degenerate) |-> (rsp_chan.data.qw == 0 && rsp_chan.data.qx == 0 && rsp_chan.data.qy == 0 && rsp_chan.data.qz == 0), "degenerate response with nonzero components")
   `RMQ_ASSERT(a_root_floor, (vld_ff[S_RND-1] && !side_ff[S_RND-1].degen) |-> (sq_root[SQ_W] >= SQ_W'(64)), "root too small for a positive argument")
   `RMQ_ASSERT_NR(a_reset_empty, $past(reset) |-> !rsp_chan.valid, "response valid right after reset")

endmodule
